// ----- hw/rtl/bucket_brigade_shift_register_unit_assert.svh -----
// assertion macros for the bucket brigade shift register unit
`ifndef BUCKET_BRIGADE_SHIFT_REGISTER_UNIT_ASSERT_SVH
`define BUCKET_BRIGADE_SHIFT_REGISTER_UNIT_ASSERT_SVH

`ifndef SYNTH
`define BBSR_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("bbsr assertion failed");
`define BBSR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bbsr assertion failed");
`else
`define BBSR_ASSERT(lbl, prop)
`define BBSR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- hw/rtl/bbsr_pkg.sv -----
// shared types and constants for the bucket brigade shift register
package bbsr_pkg;

	localparam int STAGES     = 16;
	localparam int MAX_ACTIVE = (STAGES < 16) ? STAGES : 16;
	localparam int SEL_W      = (STAGES > 1) ? $clog2(STAGES) : 1;
	localparam int IDX_W      = 4;
	localparam int CNT_CFG_W  = 5;
	localparam int WORD_W     = 32;
	localparam int CFG_IDX_W  = 3;

	typedef enum logic [2:0] {
		REQ_PUSH  = 3'd0,
		REQ_BANG  = 3'd1,
		REQ_SET   = 3'd2,
		REQ_CLEAR = 3'd3,
		REQ_ROLL  = 3'd4
	} req_t;

	typedef enum logic [2:0] {
		CFG_STAGE_COUNT = 3'd0,
		CFG_ECHO        = 3'd1,
		CFG_DIR         = 3'd2,
		CFG_FROZEN      = 3'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_SHIFT,
		OP_FILL,
		OP_CLEAR
	} cell_op_t;

	typedef struct packed {
		logic              kind;
		logic [WORD_W-1:0] bits;
	} word_t;

	typedef struct packed {
		cell_op_t op;
		logic     dir;
		logic     snap_load;
		logic     snap_next;
		logic     snap_shift;
		word_t    din;
	} cell_ctl_t;

endpackage

// ----- hw/rtl/bbsr_cell.sv -----
// one stage of the shift chain with its burst snapshot register
module bbsr_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  bbsr_pkg::cell_ctl_t ctl,
	input  logic              active,
	input  logic              at_top,
	input  bbsr_pkg::word_t   lo_word,
	input  bbsr_pkg::word_t   hi_word,
	input  bbsr_pkg::word_t   lo_snap,
	output bbsr_pkg::word_t   word,
	output bbsr_pkg::word_t   snap
);

	bbsr_pkg::word_t word_q;
	bbsr_pkg::word_t snap_q;
	bbsr_pkg::word_t word_nxt;

	always_comb begin
		word_nxt = word_q;
		case (ctl.op)
			bbsr_pkg::OP_SHIFT: begin
				if (active) begin
					if (ctl.dir) begin
						word_nxt = at_top ? ctl.din : hi_word;
					end else begin
						word_nxt = lo_word;
					end
				end
			end
			bbsr_pkg::OP_FILL: begin
				if (active) begin
					word_nxt = ctl.din;
				end
			end
			bbsr_pkg::OP_CLEAR: begin
				word_nxt = '0;
			end
			default: begin
				word_nxt = word_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else begin
			word_q <= word_nxt;
		end
	end

	// snapshot chain moves toward the high end during a burst
	always_ff @(posedge clk) begin
		if (ctl.snap_load) begin
			snap_q <= ctl.snap_next ? word_nxt : word_q;
		end else if (ctl.snap_shift) begin
			snap_q <= lo_snap;
		end
	end

	assign word = word_q;
	assign snap = snap_q;

endmodule

// ----- hw/rtl/bucket_brigade_shift_register_unit.sv -----
// top level of the bucket brigade shift register: control, config and output stage
//
// channel   handshake              payload
// req       req_valid / req_stall  req_type, value, value_is_float
// rsp       rsp_valid / rsp_stall  stage_index, stage_value, stage_is_float, last
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// push, bang, set and roll send a burst of n beats for n active stages, one beat per stage
// clear and unknown requests, and any request while output is frozen, send no beats
// the burst length is set by the active stage count; the snapshot chain moves one stage per beat
// req_stall is high while a burst is being sent; rsp_stall holds the output register
// reset zeroes every stage and loads stage_count 1; snapshot registers are not reset, all others reset to 0
module bucket_brigade_shift_register_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  logic [2:0]                      req_type,
	input  logic [bbsr_pkg::WORD_W-1:0]     value,
	input  logic                            value_is_float,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output logic [bbsr_pkg::IDX_W-1:0]      stage_index,
	output logic [bbsr_pkg::WORD_W-1:0]     stage_value,
	output logic                            stage_is_float,
	output logic                            last,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bbsr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bbsr_pkg::WORD_W-1:0]     cfg_data
);

	`include "bucket_brigade_shift_register_unit_assert.svh"

	typedef enum logic {
		ST_IDLE,
		ST_BURST
	} state_t;

	state_t                                state_q;
	logic [bbsr_pkg::IDX_W-1:0]            cnt_q;
	logic                                  rsp_valid_q;
	logic [bbsr_pkg::IDX_W-1:0]            rsp_index_q;
	bbsr_pkg::word_t                       rsp_word_q;
	logic                                  rsp_last_q;

	logic [bbsr_pkg::CNT_CFG_W-1:0]        cfg_count_q;
	logic                                  cfg_echo_q;
	logic                                  cfg_dir_q;
	logic                                  cfg_frozen_q;

	logic [bbsr_pkg::IDX_W-1:0]            top_idx;
	logic [bbsr_pkg::SEL_W-1:0]            top_sel;
	logic                                  accept;
	logic                                  ld;
	logic                                  start_burst;
	bbsr_pkg::word_t                       far_word;
	bbsr_pkg::cell_ctl_t                   ctl;

	bbsr_pkg::word_t                       word_w [bbsr_pkg::STAGES];
	bbsr_pkg::word_t                       snap_w [bbsr_pkg::STAGES];

	// active stage count, zero acts as one and values above MAX_ACTIVE saturate
	always_comb begin
		if (cfg_count_q == '0) begin
			top_idx = '0;
		end else if (int'(cfg_count_q) > bbsr_pkg::MAX_ACTIVE) begin
			top_idx = bbsr_pkg::IDX_W'(bbsr_pkg::MAX_ACTIVE - 1);
		end else begin
			top_idx = bbsr_pkg::IDX_W'(cfg_count_q - 1'b1);
		end
	end

	assign top_sel   = bbsr_pkg::SEL_W'(top_idx);
	assign far_word  = cfg_dir_q ? word_w[0] : word_w[top_sel];
	assign req_stall = (state_q == ST_BURST);
	assign accept    = req_valid && !req_stall;
	assign ld        = (state_q == ST_BURST) && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		ctl.op         = bbsr_pkg::OP_HOLD;
		ctl.dir        = cfg_dir_q;
		ctl.snap_load  = 1'b0;
		ctl.snap_next  = 1'b0;
		ctl.snap_shift = ld;
		ctl.din.kind   = value_is_float;
		ctl.din.bits   = value;
		start_burst    = 1'b0;
		if (accept) begin
			case (req_type)
				bbsr_pkg::REQ_PUSH: begin
					ctl.op        = bbsr_pkg::OP_SHIFT;
					ctl.snap_load = 1'b1;
					ctl.snap_next = cfg_echo_q;
					start_burst   = !cfg_frozen_q;
				end
				bbsr_pkg::REQ_ROLL: begin
					ctl.op        = bbsr_pkg::OP_SHIFT;
					ctl.din       = far_word;
					ctl.snap_load = 1'b1;
					ctl.snap_next = cfg_echo_q;
					start_burst   = !cfg_frozen_q;
				end
				bbsr_pkg::REQ_BANG: begin
					ctl.snap_load = 1'b1;
					start_burst   = !cfg_frozen_q;
				end
				bbsr_pkg::REQ_SET: begin
					ctl.op        = bbsr_pkg::OP_FILL;
					ctl.snap_load = 1'b1;
					ctl.snap_next = 1'b1;
					start_burst   = !cfg_frozen_q;
				end
				bbsr_pkg::REQ_CLEAR: begin
					ctl.op = bbsr_pkg::OP_CLEAR;
				end
				default: begin
					ctl.op = bbsr_pkg::OP_HOLD;
				end
			endcase
		end
	end

	for (genvar i = 0; i < bbsr_pkg::STAGES; i++) begin : g_cell
		bbsr_pkg::word_t lo_word;
		bbsr_pkg::word_t hi_word;
		bbsr_pkg::word_t lo_snap;

		if (i == 0) begin : g_lo_end
			assign lo_word = ctl.din;
			assign lo_snap = '0;
		end else begin : g_lo
			assign lo_word = word_w[i-1];
			assign lo_snap = snap_w[i-1];
		end

		if (i == bbsr_pkg::STAGES - 1) begin : g_hi_end
			assign hi_word = ctl.din;
		end else begin : g_hi
			assign hi_word = word_w[i+1];
		end

		bbsr_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.active  (i <= int'(top_idx)),
			.at_top  (i == int'(top_idx)),
			.lo_word (lo_word),
			.hi_word (hi_word),
			.lo_snap (lo_snap),
			.word    (word_w[i]),
			.snap    (snap_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_index_q <= '0;
			rsp_word_q  <= '0;
			rsp_last_q  <= 1'b0;
		end else begin
			if (ld) begin
				rsp_valid_q <= 1'b1;
				rsp_index_q <= cnt_q;
				rsp_word_q  <= snap_w[top_sel];
				rsp_last_q  <= (cnt_q == '0);
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (start_burst) begin
						state_q <= ST_BURST;
						cnt_q   <= top_idx;
					end
				end
				ST_BURST: begin
					if (ld) begin
						cnt_q <= cnt_q - 1'b1;
						if (cnt_q == '0) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_count_q  <= bbsr_pkg::CNT_CFG_W'(1);
			cfg_echo_q   <= 1'b0;
			cfg_dir_q    <= 1'b0;
			cfg_frozen_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bbsr_pkg::CFG_STAGE_COUNT: cfg_count_q  <= cfg_data[bbsr_pkg::CNT_CFG_W-1:0];
				bbsr_pkg::CFG_ECHO:        cfg_echo_q   <= cfg_data[0];
				bbsr_pkg::CFG_DIR:         cfg_dir_q    <= cfg_data[0];
				bbsr_pkg::CFG_FROZEN:      cfg_frozen_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign stage_index    = rsp_index_q;
	assign stage_value    = rsp_word_q.bits;
	assign stage_is_float = rsp_word_q.kind;
	assign last           = rsp_last_q;

	`BBSR_ASSERT(a_last_on_zero, !rsp_valid_q || (rsp_last_q == (rsp_index_q == '0)))
	`BBSR_ASSERT(a_index_in_range, !rsp_valid_q || (rsp_index_q <= top_idx))
	`BBSR_ASSERT_NEXT(a_cnt_step, ld && (cnt_q != '0), cnt_q == $past(cnt_q) - 1'b1)
	`BBSR_ASSERT_NEXT(a_bang_starts, accept && (req_type == bbsr_pkg::REQ_BANG) && !cfg_frozen_q, state_q == ST_BURST)

endmodule

// ----- tb/sv/tb_top.sv -----
// self-checking testbench for the bucket brigade shift register unit
`timescale 1ns / 1ps

module tb_top;

	localparam logic [2:0] REQ_UNKNOWN_FIRST = 3'd5;
	localparam logic [2:0] REQ_UNKNOWN_LAST  = 3'd7;
	localparam logic [2:0] CFG_UNUSED_FIRST  = 3'd4;
	localparam logic [2:0] CFG_UNUSED_LAST   = 3'd7;
	localparam int         SETTLE_CYCLES     = 24;
	localparam int         RANDOM_ITEMS      = 380;

	typedef logic [bbsr_pkg::WORD_W-1:0] word_arr_t [bbsr_pkg::STAGES];
	typedef logic                        kind_arr_t [bbsr_pkg::STAGES];

	typedef struct {
		logic [bbsr_pkg::IDX_W-1:0]  idx;
		logic [bbsr_pkg::WORD_W-1:0] word;
		logic                        kind;
		logic                        fin;
	} beat_t;

	logic                           clk;
	logic                           arst_n;
	logic                           req_valid;
	logic                           req_stall;
	logic [2:0]                     req_type;
	logic [bbsr_pkg::WORD_W-1:0]    value;
	logic                           value_is_float;
	logic                           rsp_valid;
	logic                           rsp_stall;
	logic [bbsr_pkg::IDX_W-1:0]     stage_index;
	logic [bbsr_pkg::WORD_W-1:0]    stage_value;
	logic                           stage_is_float;
	logic                           last;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [bbsr_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [bbsr_pkg::WORD_W-1:0]    cfg_data;

	// mirror of the stages and the registers
	word_arr_t   brigade_word;
	kind_arr_t   brigade_kind;
	logic [4:0]  cur_count;
	logic        cur_echo;
	logic        cur_dir;
	logic        cur_frozen;

	beat_t       pending_beats [$];
	int unsigned fail_count;
	int unsigned long_hold_cycles;
	bit          no_idle;

	bucket_brigade_shift_register_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.req_type       (req_type),
		.value          (value),
		.value_is_float (value_is_float),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.stage_index    (stage_index),
		.stage_value    (stage_value),
		.stage_is_float (stage_is_float),
		.last           (last),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(8_000_000);
		$display("Regression FAIL");
		$finish;
	end

	function automatic int unsigned active_stages();
		int unsigned n;
		n = cur_count;
		if (n < 1) n = 1;
		if (n > bbsr_pkg::MAX_ACTIVE) n = bbsr_pkg::MAX_ACTIVE;
		return n;
	endfunction

	function automatic void shift_word(int unsigned n, logic [bbsr_pkg::WORD_W-1:0] w,
		logic k);
		int i;
		if (cur_dir) begin
			for (i = 0; i + 1 < n; i++) begin
				brigade_word[i] = brigade_word[i + 1];
				brigade_kind[i] = brigade_kind[i + 1];
			end
			brigade_word[n - 1] = w;
			brigade_kind[n - 1] = k;
		end else begin
			for (i = n - 1; i > 0; i--) begin
				brigade_word[i] = brigade_word[i - 1];
				brigade_kind[i] = brigade_kind[i - 1];
			end
			brigade_word[0] = w;
			brigade_kind[0] = k;
		end
	endfunction

	function automatic void queue_burst(int unsigned n, word_arr_t snap_w, kind_arr_t snap_k);
		beat_t b;
		int s;
		if (cur_frozen) return;
		for (s = n - 1; s >= 0; s--) begin
			b.idx  = s[bbsr_pkg::IDX_W-1:0];
			b.word = snap_w[s];
			b.kind = snap_k[s];
			b.fin  = (s == 0);
			pending_beats.push_back(b);
		end
	endfunction

	function automatic void push_word(int unsigned n, logic [bbsr_pkg::WORD_W-1:0] w,
		logic k);
		word_arr_t snap_w;
		kind_arr_t snap_k;
		if (cur_echo) begin
			shift_word(n, w, k);
			snap_w = brigade_word;
			snap_k = brigade_kind;
		end else begin
			snap_w = brigade_word;
			snap_k = brigade_kind;
			shift_word(n, w, k);
		end
		queue_burst(n, snap_w, snap_k);
	endfunction

	function automatic void predict_request(logic [2:0] rt, logic [bbsr_pkg::WORD_W-1:0] w,
		logic k);
		int unsigned n;
		int unsigned far;
		int i;
		n = active_stages();
		case (rt)
			bbsr_pkg::REQ_PUSH: push_word(n, w, k);
			bbsr_pkg::REQ_BANG: queue_burst(n, brigade_word, brigade_kind);
			bbsr_pkg::REQ_SET: begin
				for (i = 0; i < n; i++) begin
					brigade_word[i] = w;
					brigade_kind[i] = k;
				end
				queue_burst(n, brigade_word, brigade_kind);
			end
			bbsr_pkg::REQ_CLEAR: begin
				for (i = 0; i < bbsr_pkg::STAGES; i++) begin
					brigade_word[i] = '0;
					brigade_kind[i] = 1'b0;
				end
			end
			bbsr_pkg::REQ_ROLL: begin
				far = cur_dir ? 0 : n - 1;
				push_word(n, brigade_word[far], brigade_kind[far]);
			end
			default: ;
		endcase
	endfunction

	function automatic int unsigned sender_gap();
		int unsigned r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// receiver side: random stalls, plus a long hold-off on request
	initial begin
		int unsigned hold_left;
		int unsigned r;
		rsp_stall = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (long_hold_cycles != 0) begin
				hold_left = long_hold_cycles;
				long_hold_cycles = 0;
			end
			if (hold_left != 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else if (no_idle) begin
				rsp_stall <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					rsp_stall <= 1'b0;
				end else begin
					rsp_stall <= 1'b1;
					if (r < 96) hold_left = $urandom_range(0, 2);
					else hold_left = $urandom_range(8, 19);
				end
			end
		end
	end

	// result checker
	always @(posedge clk) begin : check_beats
		beat_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_beats.size() == 0) begin
				$display("%0t unexpected beat: stage %0d value %h float %b last %b", $time,
					stage_index, stage_value, stage_is_float, last);
				fail_count++;
			end else begin
				want = pending_beats.pop_front();
				if (stage_index !== want.idx || stage_value !== want.word ||
					stage_is_float !== want.kind || last !== want.fin) begin
					$display("%0t beat mismatch: expected stage %0d value %h float %b last %b",
						$time, want.idx, want.word, want.kind, want.fin);
					$display("%0t                  actual stage %0d value %h float %b last %b",
						$time, stage_index, stage_value, stage_is_float, last);
					fail_count++;
				end
			end
		end
	end

	task automatic send_req(input logic [2:0] rt, input logic [bbsr_pkg::WORD_W-1:0] w,
		input logic k);
		int unsigned gap;
		req_type       <= rt;
		value          <= w;
		value_is_float <= k;
		req_valid      <= 1'b1;
		do @(posedge clk); while (req_stall);
		predict_request(rt, w, k);
		gap = sender_gap();
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_and_settle();
		req_valid <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [bbsr_pkg::CFG_IDX_W-1:0] idx,
		input logic [bbsr_pkg::WORD_W-1:0] data);
		drain_and_settle();
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			bbsr_pkg::CFG_STAGE_COUNT: cur_count  = data[4:0];
			bbsr_pkg::CFG_ECHO:        cur_echo   = data[0];
			bbsr_pkg::CFG_DIR:         cur_dir    = data[0];
			bbsr_pkg::CFG_FROZEN:      cur_frozen = data[0];
			default: ;
		endcase
	endtask

	// upper data bits are junk on purpose
	task automatic set_config(input logic [4:0] cnt, input logic echo, input logic dir,
		input logic frozen);
		write_reg(bbsr_pkg::CFG_STAGE_COUNT, ($urandom() & ~32'h1f) | cnt);
		write_reg(bbsr_pkg::CFG_ECHO, ($urandom() & ~32'h1) | echo);
		write_reg(bbsr_pkg::CFG_DIR, ($urandom() & ~32'h1) | dir);
		write_reg(bbsr_pkg::CFG_FROZEN, ($urandom() & ~32'h1) | frozen);
	endtask

	function automatic logic [bbsr_pkg::WORD_W-1:0] pick_value();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 3) return 32'h0000_0000;
		if (r < 6) return 32'hffff_ffff;
		if (r < 8) return 32'h8000_0000;
		if (r < 10) return 32'h7fff_ffff;
		return $urandom();
	endfunction

	function automatic logic [2:0] pick_req();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 40) return bbsr_pkg::REQ_PUSH;
		if (r < 60) return bbsr_pkg::REQ_ROLL;
		if (r < 75) return bbsr_pkg::REQ_BANG;
		if (r < 87) return bbsr_pkg::REQ_SET;
		if (r < 94) return bbsr_pkg::REQ_CLEAR;
		return 3'($urandom_range(REQ_UNKNOWN_FIRST, REQ_UNKNOWN_LAST));
	endfunction

	function automatic logic [4:0] pick_count();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return 5'($urandom_range(1, 4));
		if (r < 80) return 5'($urandom_range(5, 15));
		if (r < 90) return 5'd16;
		if (r < 95) return 5'd0;
		return 5'($urandom_range(17, 31));
	endfunction

	task automatic test_reset_state();
		send_req(bbsr_pkg::REQ_BANG, 32'h0, 1'b0);
	endtask

	task automatic test_directed();
		set_config(5'd4, 1'b0, 1'b0, 1'b0);
		send_req(bbsr_pkg::REQ_PUSH, 32'hffff_ffff, 1'b1);
		send_req(bbsr_pkg::REQ_PUSH, 32'h0000_0000, 1'b0);
		send_req(bbsr_pkg::REQ_PUSH, 32'h8000_0000, 1'b0);
		send_req(bbsr_pkg::REQ_PUSH, 32'h7fff_ffff, 1'b1);
		send_req(bbsr_pkg::REQ_BANG, 32'h1234_5678, 1'b1);
		send_req(bbsr_pkg::REQ_ROLL, 32'h0, 1'b0);
		send_req(bbsr_pkg::REQ_SET, 32'h3f80_0000, 1'b1);
		set_config(5'd4, 1'b1, 1'b1, 1'b0);
		send_req(bbsr_pkg::REQ_PUSH, 32'hdead_beef, 1'b0);
		send_req(bbsr_pkg::REQ_ROLL, 32'hffff_ffff, 1'b1);
		send_req(bbsr_pkg::REQ_CLEAR, 32'hffff_ffff, 1'b1);
		send_req(bbsr_pkg::REQ_BANG, 32'h0, 1'b0);
		send_req(REQ_UNKNOWN_FIRST, 32'hffff_ffff, 1'b1);
		send_req(REQ_UNKNOWN_LAST, 32'h5555_aaaa, 1'b0);
		// state moves on while output is frozen
		set_config(5'd4, 1'b0, 1'b0, 1'b1);
		send_req(bbsr_pkg::REQ_PUSH, 32'hcafe_f00d, 1'b1);
		send_req(bbsr_pkg::REQ_SET, 32'h0bad_0001, 1'b0);
		send_req(bbsr_pkg::REQ_ROLL, 32'h0, 1'b0);
		set_config(5'd0, 1'b0, 1'b0, 1'b0);
		send_req(bbsr_pkg::REQ_PUSH, 32'h0000_0001, 1'b0);
		send_req(bbsr_pkg::REQ_BANG, 32'h0, 1'b0);
		set_config(5'd31, 1'b1, 1'b0, 1'b0);
		send_req(bbsr_pkg::REQ_BANG, 32'h0, 1'b0);
		send_req(bbsr_pkg::REQ_ROLL, 32'h0, 1'b1);
		set_config(5'd16, 1'b0, 1'b1, 1'b0);
		send_req(bbsr_pkg::REQ_ROLL, 32'h0, 1'b0);
		send_req(bbsr_pkg::REQ_PUSH, 32'h7f80_0000, 1'b1);
		write_reg(CFG_UNUSED_FIRST, $urandom());
		write_reg(CFG_UNUSED_LAST, $urandom());
		send_req(bbsr_pkg::REQ_BANG, 32'h0, 1'b0);
	endtask

	task automatic test_backpressure();
		int i;
		set_config(5'd16, 1'b0, 1'b0, 1'b0);
		long_hold_cycles = 300;
		no_idle = 1'b1;
		for (i = 0; i < 12; i++) send_req(pick_req(), pick_value(), 1'($urandom_range(0, 1)));
		no_idle = 1'b0;
	endtask

	task automatic test_sender_pause();
		int i;
		set_config(5'd3, 1'b1, 1'b0, 1'b0);
		for (i = 0; i < 6; i++) send_req(pick_req(), pick_value(), 1'($urandom_range(0, 1)));
		req_valid <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		for (i = 0; i < 6; i++) send_req(pick_req(), pick_value(), 1'($urandom_range(0, 1)));
	endtask

	task automatic test_random();
		int unsigned sent;
		int unsigned phase_items;
		int unsigned i;
		logic [2:0]  rt;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			set_config(pick_count(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				$urandom_range(0, 99) < 15);
			no_idle = ($urandom_range(0, 99) < 20);
			phase_items = $urandom_range(20, 40);
			i = 0;
			while (i < phase_items) begin
				rt = pick_req();
				send_req(rt, pick_value(), 1'($urandom_range(0, 1)));
				if (rt < REQ_UNKNOWN_FIRST) i++;
			end
			sent += phase_items;
			no_idle = 1'b0;
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		req_valid        = 1'b0;
		req_type         = bbsr_pkg::REQ_PUSH;
		value            = '0;
		value_is_float   = 1'b0;
		cfg_valid        = 1'b0;
		cfg_index        = bbsr_pkg::CFG_STAGE_COUNT;
		cfg_data         = '0;
		fail_count       = 0;
		long_hold_cycles = 0;
		no_idle          = 1'b0;
		cur_count        = 5'd1;
		cur_echo         = 1'b0;
		cur_dir          = 1'b0;
		cur_frozen       = 1'b0;
		for (int i = 0; i < bbsr_pkg::STAGES; i++) begin
			brigade_word[i] = '0;
			brigade_kind[i] = 1'b0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_state();
		test_directed();
		test_backpressure();
		test_sender_pause();
		test_random();

		drain_and_settle();
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/bbsr_pkg.sv
hw/rtl/bbsr_cell.sv
hw/rtl/bucket_brigade_shift_register_unit.sv
tb/sv/tb_top.sv
